[sv/rcpd_pkg.sv]
// Shared types and constants for the 128-by-64 reciprocal divider.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package rcpd_pkg;

    localparam int            SEED_ENTRIES = 256;
    localparam int            SEED_W       = 11;
    localparam logic [19:0]   SEED_NUM     = 20'h7fd00;
    localparam logic [63:0]   NEWTON_ONE   = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] dividend_high;
        logic [63:0] dividend_low;
        logic [63:0] divisor;
    } item_t;

    typedef struct packed {
        logic [63:0] quotient;
        logic [63:0] remainder;
        logic [63:0] reciprocal;
        logic        bad_operands;
    } result_t;

    // Per-word data that rides alongside the multipliers.
    typedef struct packed {
        logic        bad;
        logic        norm;
        logic [63:0] d;
        logic [63:0] nh;
        logic [63:0] nl;
        logic [63:0] val;
        logic [63:0] q0;
        logic [63:0] q1;
    } side_t;

endpackage

[sv/reciprocal_divide_128_by_64.sv]
// Path from accepted word to result: eight pipelined multiplier steps plus two
// correction stages. Throughput: one word per cycle while no result waits stalled.
// The whole pipeline advances together; it holds while a result waits stalled.
// Reset (rst_n low, asynchronous) clears all valid bits; data needs no reset.
// Depends on rcpd_pkg, rcpd_recip, rcpd_div.
`timescale 1ns / 1ps

module reciprocal_divide_128_by_64 (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  rcpd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output rcpd_pkg::result_t result
);
    import rcpd_pkg::*;

    logic  en;
    logic  rc_valid;
    side_t rc_side;

    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;

    rcpd_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item_valid),
        .in_item   (item),
        .out_valid (rc_valid),
        .out_side  (rc_side)
    );

    rcpd_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (rc_valid),
        .in_side    (rc_side),
        .out_valid  (result_valid),
        .out_result (result)
    );

endmodule

[sv/rcpd_mul.sv]
// Three-stage pipelined 64x64 -> 128 multiplier with sideband data.
// Depends on rcpd_pkg.
`timescale 1ns / 1ps

module rcpd_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [63:0]     a,
    input  logic [63:0]     b,
    input  rcpd_pkg::side_t in_side,
    output logic            out_valid,
    output logic [127:0]    prod,
    output rcpd_pkg::side_t out_side
);
    import rcpd_pkg::*;

    logic        v0_reg, v1_reg, v2_reg;
    logic [63:0] a_reg, b_reg;
    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [127:0] prod_reg;
    side_t       side0_reg, side1_reg, side2_reg;
    logic [127:0] prod_next;

    always_comb
    begin
        prod_next = {64'd0, ll_reg} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0}
                  + {hh_reg, 64'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a;
            b_reg     <= b;
            side0_reg <= in_side;
            ll_reg    <= a_reg[31:0] * b_reg[31:0];
            lh_reg    <= a_reg[31:0] * b_reg[63:32];
            hl_reg    <= a_reg[63:32] * b_reg[31:0];
            hh_reg    <= a_reg[63:32] * b_reg[63:32];
            side1_reg <= side0_reg;
            prod_reg  <= prod_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign prod      = prod_reg;
    assign out_side  = side2_reg;

endmodule

[sv/rcpd_recip.sv]
// Reciprocal pipeline: seed ROM, three Newton steps (v1, v2, v3), final correction.
// Depends on rcpd_pkg and rcpd_mul.
`timescale 1ns / 1ps

module rcpd_recip (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rcpd_pkg::item_t in_item,
    output logic            out_valid,
    output rcpd_pkg::side_t out_side
);
    import rcpd_pkg::*;

    logic [SEED_W-1:0] seed_rom [SEED_ENTRIES];

    for (genvar g = 0; g < SEED_ENTRIES; g++)
    begin : g_seed
        localparam logic [SEED_W-1:0] SEED = SEED_W'(SEED_NUM / (g + SEED_ENTRIES));
        assign seed_rom[g] = SEED;
    end

    function automatic logic [63:0] d40_of(input logic [63:0] d);
        return {23'd0, {1'b0, d[63:24]} + 41'd1};
    endfunction

    logic [SEED_W-1:0] v0;
    logic [21:0]       v0sq;
    side_t             s_in;

    logic        mv   [6];
    logic [63:0] ma   [6];
    logic [63:0] mb   [6];
    side_t       ms   [6];
    logic        ov   [6];
    logic [127:0] op  [6];
    side_t       os   [6];

    always_comb
    begin
        v0        = seed_rom[in_item.divisor[62:55]];
        v0sq      = 22'(v0) * 22'(v0);
        s_in      = '0;
        s_in.d    = in_item.divisor;
        s_in.nh   = in_item.dividend_high;
        s_in.nl   = in_item.dividend_low;
        s_in.norm = in_item.divisor[63];
        s_in.bad  = !in_item.divisor[63] || (in_item.dividend_high >= in_item.divisor);
        s_in.val  = 64'(v0);
        mv[0] = in_valid;
        ma[0] = 64'(v0sq);
        mb[0] = d40_of(in_item.divisor);
        ms[0] = s_in;
    end

    // v1 = (v0 << 11) - ((v0*v0*d40) >> 40) - 1
    always_comb
    begin
        mv[1] = ov[0];
        ms[1] = os[0];
        ms[1].val = (os[0].val << 11) - (op[0][63:0] >> 40) - 64'd1;
        ma[1] = ms[1].val;
        mb[1] = d40_of(os[0].d);
    end

    // t = 2^60 - v1*d40
    always_comb
    begin
        mv[2] = ov[1];
        ms[2] = os[1];
        ma[2] = os[1].val;
        mb[2] = NEWTON_ONE - op[1][63:0];
    end

    // v2 = (v1 << 13) + ((v1*t) >> 47)
    always_comb
    begin
        mv[3] = ov[2];
        ms[3] = os[2];
        ms[3].val = (os[2].val << 13) + (op[2][63:0] >> 47);
        ma[3] = ms[3].val;
        mb[3] = (os[2].d >> 1) + 64'(os[2].d[0]);
    end

    // e = ((v2 >> 1) & odd mask) - v2*d63
    always_comb
    begin
        mv[4] = ov[3];
        ms[4] = os[3];
        ma[4] = os[3].val;
        mb[4] = ((os[3].val >> 1) & {64{os[3].d[0]}}) - op[3][63:0];
    end

    // v3 = (hi(v2*e) >> 1) + (v2 << 31)
    always_comb
    begin
        mv[5] = ov[4];
        ms[5] = os[4];
        ms[5].val = (op[4][127:64] >> 1) + (os[4].val << 31);
        ma[5] = ms[5].val;
        mb[5] = os[4].d;
    end

    for (genvar k = 0; k < 6; k++)
    begin : g_mul
        rcpd_mul u_mul (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (mv[k]),
            .a         (ma[k]),
            .b         (mb[k]),
            .in_side   (ms[k]),
            .out_valid (ov[k]),
            .prod      (op[k]),
            .out_side  (os[k])
        );
    end

    // v = v3 - hi(v3*d + d) - d, zero for an unnormalized divisor
    logic [64:0] lo_sum;
    logic [63:0] hi_word;

    always_comb
    begin
        lo_sum   = {1'b0, op[5][63:0]} + {1'b0, os[5].d};
        hi_word  = op[5][127:64] + 64'(lo_sum[64]);
        out_side = os[5];
        out_side.val = os[5].norm ? (os[5].val - hi_word - os[5].d) : 64'd0;
    end

    assign out_valid = ov[5];

endmodule

[sv/rcpd_div.sv]
// 2-by-1 reciprocal division: quotient estimate, remainder, two corrections.
// Depends on rcpd_pkg and rcpd_mul.
`timescale 1ns / 1ps

module rcpd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rcpd_pkg::side_t   in_side,
    output logic              out_valid,
    output rcpd_pkg::result_t out_result
);
    import rcpd_pkg::*;

    logic         v7, v8;
    logic [127:0] p7, p8;
    side_t        s7, s8, s8_in;
    logic [64:0]  q0_sum;
    logic         v8_in_valid;

    rcpd_mul u_mul_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .a         (in_side.val),
        .b         (in_side.nh),
        .in_side   (in_side),
        .out_valid (v7),
        .prod      (p7),
        .out_side  (s7)
    );

    always_comb
    begin
        q0_sum   = {1'b0, p7[63:0]} + {1'b0, s7.nl};
        s8_in    = s7;
        s8_in.q0 = q0_sum[63:0];
        s8_in.q1 = p7[127:64] + s7.nh + 64'(q0_sum[64]) + 64'd1;
    end

    assign v8_in_valid = v7;

    rcpd_mul u_mul_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_in_valid),
        .a         (s8_in.q1),
        .b         (s8_in.d),
        .in_side   (s8_in),
        .out_valid (v8),
        .prod      (p8),
        .out_side  (s8)
    );

    // first correction
    logic        c1_valid_reg;
    logic [63:0] c1_q_reg, c1_r_reg, c1_d_reg, c1_v_reg;
    logic        c1_bad_reg;
    logic [63:0] r_raw, c1_q_next, c1_r_next;

    always_comb
    begin
        r_raw = s8.nl - p8[63:0];
        if (r_raw > s8.q0)
        begin
            c1_q_next = s8.q1 - 64'd1;
            c1_r_next = r_raw + s8.d;
        end
        else
        begin
            c1_q_next = s8.q1;
            c1_r_next = r_raw;
        end
    end

    // second correction and output register
    logic    out_valid_reg;
    result_t out_reg, out_next;

    always_comb
    begin
        out_next.reciprocal   = c1_v_reg;
        out_next.bad_operands = c1_bad_reg;
        if (c1_bad_reg)
        begin
            out_next.quotient  = 64'd0;
            out_next.remainder = 64'd0;
        end
        else if (c1_r_reg >= c1_d_reg)
        begin
            out_next.quotient  = c1_q_reg + 64'd1;
            out_next.remainder = c1_r_reg - c1_d_reg;
        end
        else
        begin
            out_next.quotient  = c1_q_reg;
            out_next.remainder = c1_r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg  <= v8;
            out_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_q_reg   <= c1_q_next;
            c1_r_reg   <= c1_r_next;
            c1_d_reg   <= s8.d;
            c1_v_reg   <= s8.val;
            c1_bad_reg <= s8.bad;
            out_reg    <= out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

[sv/rcpd_checker.sv]
// Port-level checks for reciprocal_divide_128_by_64, bound to the top level.
// Depends on rcpd_pkg.
`timescale 1ns / 1ps

module rcpd_props (
    input logic              clk,
    input logic              rst_n,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input rcpd_pkg::result_t result
);
    import rcpd_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // input backpressure only comes from a stalled result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall))
        else $error("input stall mismatch");

    // flagged operands give zero quotient and remainder
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_operands |->
            result.quotient == 64'd0 && result.remainder == 64'd0)
        else $error("bad operands with nonzero result");

endmodule

bind reciprocal_divide_128_by_64 rcpd_props u_rcpd_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
